// ===== src/accm_pkg.sv =====
// ----------------------------------------------------------------------------
// accm_pkg: shared types, codes and AES helper functions
// Holds the operation and result codes, the queue entry type and the
// byte-level AES primitives used by the round core and the key schedule.
// ----------------------------------------------------------------------------
package accm_pkg;

    localparam int BLK_BYTES = 16;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_FINISH  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_TAG     = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CFG_KEY_HIGH   = 3'd0,
        CFG_KEY_LOW    = 3'd1,
        CFG_NONCE_HIGH = 3'd2,
        CFG_NONCE_LOW  = 3'd3,
        CFG_TAG_LEN    = 3'd4,
        CFG_HDR_LEN    = 3'd5,
        CFG_MSG_LEN    = 3'd6,
        CFG_OPEN_MODE  = 3'd7
    } cfg_idx_t;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        logic         finish;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } job_t;

    typedef enum logic [2:0] {
        BS_IDLE   = 3'd0,
        BS_B0     = 3'd1,
        BS_HDR    = 3'd2,
        BS_CTR    = 3'd3,
        BS_MAC    = 3'd4,
        BS_OUT    = 3'd5
    } bstate_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8] (big-endian).
    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    // One AES round on the state; the last round skips MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[c * 4 + i] = sbox(byte_at(s, ((c + i) & 3) * 4 + i));
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[c * 4]     = a0 ^ x ^ xtime(a0 ^ a1);
                t[c * 4 + 1] = a1 ^ x ^ xtime(a1 ^ a2);
                t[c * 4 + 2] = a2 ^ x ^ xtime(a2 ^ a3);
                t[c * 4 + 3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127 - 8 * i -: 8] = t[i];
        return o ^ rk;
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        g  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // Mask keeping the first n bytes of a block.
    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
            m[127 - 8 * i -: 8] = (i < n) ? 8'hff : 8'h00;
        return m;
    endfunction

endpackage

// ===== src/aes_ccm_seal_open_top.sv =====
// ----------------------------------------------------------------------------
// aes_ccm_seal_open_top: AES-128 CCM seal/open with a two-byte length field
// A payload beat runs the counter block and, if it holds any bytes, the
// CBC-MAC block on the single round-iterative AES core. The first payload
// or finish beat of a session first runs B_0 and then each header block
// (one or two). Header beats do not use the AES core. After a finish beat
// the input stays blocked until the session has ended and its result is
// registered. A two-entry queue separates input classification from the
// sequencer, and the result sits in an output register until taken.
// ----------------------------------------------------------------------------
module aes_ccm_seal_open_top #(
    parameter int HEADER_MAX = 30
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // word_high, word_low, valid_bytes, zero fill
    input  logic [1:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // result_high, result_low, result_bytes, tag_match
    output logic [1:0]   m_tuser   // kind
);
    import accm_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg, nonce_high_reg;
    logic [39:0]  nonce_low_reg;
    logic [4:0]   tag_len_reg, hdr_len_reg;
    logic [15:0]  msg_len_reg;
    logic         open_reg;
    logic [3:0]   tag_m;
    logic [4:0]   hdr_eff;
    logic [255:0] hdr_buf;
    logic         q_valid, q_ready, session_end, match;
    job_t         q_job;
    logic [127:0] rdata;
    logic [4:0]   rbytes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0; key_low_reg <= '0; nonce_high_reg <= '0;
            nonce_low_reg <= '0; tag_len_reg <= 5'd4; hdr_len_reg <= '0;
            msg_len_reg <= '0; open_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data[39:0];
                CFG_TAG_LEN:    tag_len_reg    <= cfg_data[4:0];
                CFG_HDR_LEN:    hdr_len_reg    <= cfg_data[4:0];
                CFG_MSG_LEN:    msg_len_reg    <= cfg_data[15:0];
                CFG_OPEN_MODE:  open_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Tag length in byte pairs, clamped to 2..8.
    assign tag_m   = (tag_len_reg < 5'd4) ? 4'd2 :
                     (tag_len_reg > 5'd16) ? 4'd8 : tag_len_reg[4:1];
    assign hdr_eff = (hdr_len_reg > 5'(HEADER_MAX)) ? 5'(HEADER_MAX) : hdr_len_reg;

    accm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_op(s_tuser),
        .s_data({s_tdata[63:0], s_tdata[127:64]}), .s_nbytes(s_tdata[132:128]),
        .hdr_len(hdr_eff), .session_end(session_end), .hdr_buf(hdr_buf),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    accm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .key({key_high_reg, key_low_reg}), .nonce({nonce_high_reg, nonce_low_reg}),
        .tag_m(tag_m), .hdr_len(hdr_eff), .msg_len(msg_len_reg), .open_mode(open_reg),
        .hdr_buf(hdr_buf), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
        .session_end(session_end), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_kind(m_tuser), .m_data(rdata), .m_nbytes(rbytes), .m_match(match)
    );

    // Word order on the bus: low 64 bits of tdata hold word_high.
    assign m_tdata = {2'b00, match, rbytes, rdata[63:0], rdata[127:64]};
endmodule

// ===== src/accm_aes_core.sv =====
// ----------------------------------------------------------------------------
// accm_aes_core: round-iterative AES-128 encryption
// One round per cycle with the key schedule expanded on the fly.
// ----------------------------------------------------------------------------
module accm_aes_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] block_in,
    output logic         done,
    output logic [127:0] block_out
);
    import accm_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] key_n;

    assign key_n = key_step(rkey_reg, rcon_reg);

    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            state_next = block_in ^ key;
            rkey_next  = key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            state_next = aes_round(state_reg, key_n, round_reg == 4'd10);
            rkey_next  = key_n;
            rcon_next  = xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd10) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
        round_reg <= round_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign block_out = state_reg;
endmodule

// ===== src/accm_front.sv =====
// ----------------------------------------------------------------------------
// accm_front: input classification and associated data buffering
// Takes input beats, stores associated data bytes while no session is
// running, drops unused codes and queues payload and finish jobs.
// ----------------------------------------------------------------------------
module accm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_op,
    input  logic [127:0]         s_data,
    input  logic [4:0]           s_nbytes,
    input  logic [4:0]           hdr_len,
    input  logic                 session_end,
    output logic [255:0]         hdr_buf,
    output logic                 q_valid,
    input  logic                 q_ready,
    output accm_pkg::job_t       q_job
);
    import accm_pkg::*;

    // Two-entry queue between front and back.
    job_t         q_mem_reg [0:1];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic [255:0] hdr_reg, hdr_next;
    logic [4:0]   seen_reg, seen_next;
    logic         started_reg;
    logic         fin_pend_reg;
    logic         acc, push, pop;
    logic [4:0]   n;
    logic [5:0]   pos;

    // Once a finish is queued, the next session's header bytes must wait
    // until the back end has used and released the current header buffer.
    assign s_tready = (cnt_reg != 2'd2) && !fin_pend_reg;
    assign acc      = s_tvalid && s_tready;
    assign n        = (s_nbytes > 5'd16) ? 5'd16 : s_nbytes;
    assign push     = acc && (s_op == OP_PAYLOAD || s_op == OP_FINISH);
    assign pop      = q_valid && q_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_job    = q_mem_reg[rp_reg];
    assign hdr_buf  = hdr_reg;

    always_comb begin
        hdr_next  = hdr_reg;
        seen_next = seen_reg;
        pos       = '0;
        if (acc && s_op == OP_HEADER && !started_reg) begin
            for (int i = 0; i < 16; i++) begin
                pos = {1'b0, seen_reg} + 6'(i);
                if (5'(i) < n && pos < {1'b0, hdr_len})
                    hdr_next[255 - 8 * pos[4:0] -: 8] = byte_at(s_data, i);
            end
            if ({1'b0, seen_reg} + {1'b0, n} > {1'b0, hdr_len})
                seen_next = (seen_reg > hdr_len) ? seen_reg : hdr_len;
            else
                seen_next = seen_reg + n;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            q_mem_reg[wp_reg] <= '{finish: s_op == OP_FINISH, data: s_data, nbytes: n};
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
            hdr_reg <= '0; seen_reg <= 5'd0; started_reg <= 1'b0;
            fin_pend_reg <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (session_end) begin
                hdr_reg <= '0; seen_reg <= 5'd0; started_reg <= 1'b0;
                fin_pend_reg <= 1'b0;
            end else begin
                hdr_reg  <= hdr_next;
                seen_reg <= seen_next;
                if (push) started_reg <= 1'b1;
                if (push && s_op == OP_FINISH) fin_pend_reg <= 1'b1;
            end
        end
    end
endmodule

// ===== src/accm_back.sv =====
// ----------------------------------------------------------------------------
// accm_back: CCM sequencer
// Builds B_0 and the header blocks, runs the counter and CBC-MAC blocks on
// the shared AES core and presents one registered result.
// ----------------------------------------------------------------------------
module accm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [127:0]       key,
    input  logic [103:0]       nonce,
    input  logic [3:0]         tag_m,
    input  logic [4:0]         hdr_len,
    input  logic [15:0]        msg_len,
    input  logic               open_mode,
    input  logic [255:0]       hdr_buf,
    input  logic               q_valid,
    output logic               q_ready,
    input  accm_pkg::job_t     q_job,
    output logic               session_end,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_kind,
    output logic [127:0]       m_data,
    output logic [4:0]         m_nbytes,
    output logic               m_match
);
    import accm_pkg::*;

    bstate_t      st_reg, st_next;
    logic [127:0] mac_reg, mac_next;
    logic [15:0]  ctr_reg, ctr_next;
    logic         phase_reg, phase_next;
    logic         hblk_reg, hblk_next;
    job_t         job_reg, job_next;
    logic [127:0] ks_reg, ks_next;
    logic         ovalid_reg, ovalid_next;
    logic [1:0]   okind_reg, okind_next;
    logic [127:0] odata_reg, odata_next;
    logic [4:0]   onb_reg, onb_next;
    logic         omatch_reg, omatch_next;
    logic         end_next;

    logic         aes_start, aes_done;
    logic [127:0] aes_in, aes_out;
    logic [255:0] hpad;
    logic [127:0] b0, ctr_blk, pmask, rmask, tagv;
    logic [4:0]   mbytes;

    accm_aes_core u_aes (
        .aclk(aclk), .aresetn(aresetn), .start(aes_start), .key(key),
        .block_in(aes_in), .done(aes_done), .block_out(aes_out)
    );

    assign hpad    = {8'h00, 3'b000, hdr_len, hdr_buf[255:16]};
    assign b0      = {1'b0, hdr_len != 5'd0, tag_m[2:0] - 3'd1, 3'b001, nonce, msg_len};
    assign mbytes  = {tag_m, 1'b0};
    assign pmask   = lead_mask(job_reg.nbytes);
    assign rmask   = lead_mask(mbytes);
    assign tagv    = (mac_reg ^ ks_reg) & rmask;

    // Counter block for the job: index zero for finish.
    assign ctr_blk = {8'h01, nonce, job_reg.finish ? 16'd0 : ctr_reg};

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            BS_IDLE: if (q_valid && !ovalid_reg) st_next = phase_reg ? BS_CTR : BS_B0;
            BS_B0:   if (aes_done) st_next = (hdr_len != 5'd0) ? BS_HDR : BS_CTR;
            BS_HDR:  if (aes_done && (hblk_reg || hdr_len <= 5'd14)) st_next = BS_CTR;
            BS_CTR:  if (aes_done)
                         st_next = (!job_reg.finish && job_reg.nbytes != 5'd0) ? BS_MAC : BS_OUT;
            BS_MAC:  if (aes_done) st_next = BS_OUT;
            BS_OUT:  st_next = BS_IDLE;
            default: st_next = BS_IDLE;
        endcase
    end

    always_comb begin
        aes_start   = 1'b0;
        aes_in      = ctr_blk;
        q_ready     = 1'b0;
        mac_next    = mac_reg;
        ctr_next    = ctr_reg;
        phase_next  = phase_reg;
        hblk_next   = hblk_reg;
        job_next    = job_reg;
        ks_next     = ks_reg;
        okind_next  = okind_reg;
        odata_next  = odata_reg;
        onb_next    = onb_reg;
        omatch_next = omatch_reg;
        end_next    = 1'b0;
        ovalid_next = ovalid_reg && !m_tready;
        case (st_reg)
            BS_IDLE: if (q_valid && !ovalid_reg) begin
                q_ready  = 1'b1;
                job_next = q_job;
                aes_start = 1'b1;
                aes_in   = phase_reg ? {8'h01, nonce, q_job.finish ? 16'd0 : ctr_reg} : b0;
                hblk_next = 1'b0;
            end
            BS_B0: if (aes_done) begin
                mac_next  = aes_out;
                aes_start = 1'b1;
                aes_in    = (hdr_len != 5'd0) ? aes_out ^ hpad[255:128] : ctr_blk;
            end
            BS_HDR: if (aes_done) begin
                mac_next  = aes_out;
                aes_start = 1'b1;
                hblk_next = 1'b1;
                aes_in    = (!hblk_reg && hdr_len > 5'd14) ? aes_out ^ hpad[127:0] : ctr_blk;
            end
            BS_CTR: if (aes_done) begin
                ks_next    = aes_out;
                phase_next = 1'b1;
                if (!job_reg.finish && job_reg.nbytes != 5'd0) begin
                    aes_start = 1'b1;
                    aes_in    = mac_reg ^ ((open_mode ? (job_reg.data ^ aes_out)
                                                      : job_reg.data) & pmask);
                end
            end
            BS_MAC: if (aes_done) begin
                mac_next = aes_out;
                ctr_next = ctr_reg + 16'd1;
            end
            BS_OUT: begin
                ovalid_next = 1'b1;
                omatch_next = 1'b0;
                if (!job_reg.finish) begin
                    okind_next = KIND_DATA;
                    odata_next = (job_reg.data ^ ks_reg) & pmask;
                    onb_next   = job_reg.nbytes;
                end else begin
                    end_next   = 1'b1;
                    phase_next = 1'b0;
                    ctr_next   = 16'd1;
                    mac_next   = '0;
                    if (open_mode) begin
                        okind_next  = KIND_VERDICT;
                        odata_next  = '0;
                        onb_next    = 5'd0;
                        omatch_next = tagv == (job_reg.data & rmask);
                    end else begin
                        okind_next = KIND_TAG;
                        odata_next = tagv;
                        onb_next   = mbytes;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        ks_reg     <= ks_next;
        okind_reg  <= okind_next;
        odata_reg  <= odata_next;
        onb_reg    <= onb_next;
        omatch_reg <= omatch_next;
        if (!aresetn) begin
            st_reg <= BS_IDLE; mac_reg <= '0; ctr_reg <= 16'd1;
            phase_reg <= 1'b0; hblk_reg <= 1'b0; ovalid_reg <= 1'b0;
            session_end <= 1'b0;
        end else begin
            st_reg <= st_next; mac_reg <= mac_next; ctr_reg <= ctr_next;
            phase_reg <= phase_next; hblk_reg <= hblk_next; ovalid_reg <= ovalid_next;
            session_end <= end_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_kind   = okind_reg;
    assign m_data   = odata_reg;
    assign m_nbytes = onb_reg;
    assign m_match  = omatch_reg;
endmodule

// ===== test/ccm_checker.sv =====
// ----------------------------------------------------------------------------
// ccm_checker: CCM seal/open result predictor and comparator
// Follows register writes and accepted input beats, computes the expected
// payload blocks, tags and verdicts with its own AES-128 and CCM state, and
// compares every accepted result beat field by field in order.
// ----------------------------------------------------------------------------
module ccm_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           pending,
    output int           fails
);
    timeunit 1ns;
    timeprecision 1ps;
    import accm_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        match;
    } ccm_result_t;

    localparam logic [7:0] SUB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    // Registers as the block should hold them.
    logic [63:0]  key_hi, key_lo, nonce_hi;
    logic [39:0]  nonce_lo;
    logic [4:0]   tag_len, hdr_len;
    logic [15:0]  msg_len;
    logic         opening;

    // Session state.
    logic [127:0] mac_value;
    logic [15:0]  ctr_index;
    logic [255:0] hdr_bytes;
    logic [4:0]   hdr_seen;
    logic         in_session;

    ccm_result_t  expected_results[$];

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes128(input logic [127:0] blk);
        logic [127:0] rk, st;
        logic [31:0]  g, w0, w1, w2, w3;
        logic [7:0]   t [16];
        logic [7:0]   rc, a0, a1, a2, a3, x;
        rk = {key_hi, key_lo};
        st = blk ^ rk;
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            w3 = rk[31:0];
            g  = {SUB[w3[23:16]] ^ rc, SUB[w3[15:8]], SUB[w3[7:0]], SUB[w3[31:24]]};
            w0 = rk[127:96] ^ g;
            w1 = rk[95:64] ^ w0;
            w2 = rk[63:32] ^ w1;
            w3 = w3 ^ w2;
            rk = {w0, w1, w2, w3};
            rc = gf_double(rc);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c * 4 + i] = SUB[st[127 - 8 * (((c + i) % 4) * 4 + i) -: 8]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[c * 4]     = a0 ^ x ^ gf_double(a0 ^ a1);
                    t[c * 4 + 1] = a1 ^ x ^ gf_double(a1 ^ a2);
                    t[c * 4 + 2] = a2 ^ x ^ gf_double(a2 ^ a3);
                    t[c * 4 + 3] = a3 ^ x ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[127 - 8 * i -: 8] = t[i];
            st = st ^ rk;
        end
        return st;
    endfunction

    function automatic logic [127:0] keep_bytes(input int n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
            m[127 - 8 * i -: 8] = (i < n) ? 8'hff : 8'h00;
        return m;
    endfunction

    function automatic int tag_bytes();
        int m;
        m = tag_len;
        if (m < 4) m = 4;
        if (m > 16) m = 16;
        return m & ~1;
    endfunction

    function automatic int header_bytes();
        return (hdr_len > 30) ? 30 : int'(hdr_len);
    endfunction

    task automatic clear_session();
        mac_value  = '0;
        ctr_index  = 16'd1;
        hdr_bytes  = '0;
        hdr_seen   = '0;
        in_session = 1'b0;
    endtask

    // B_0, then the length-prefixed, zero-padded associated data.
    task automatic open_session();
        logic [255:0] abuf;
        logic [7:0]   flags;
        int           hl;
        hl = header_bytes();
        flags = (hl != 0 ? 8'h40 : 8'h00) | 8'((tag_bytes() - 2) / 2 << 3) | 8'h01;
        mac_value = aes128({flags, nonce_hi, nonce_lo, msg_len});
        if (hl != 0) begin
            abuf = '0;
            abuf[247:240] = 8'(hl);
            for (int i = 0; i < hl; i++)
                abuf[239 - 8 * i -: 8] = hdr_bytes[255 - 8 * i -: 8];
            mac_value = aes128(mac_value ^ abuf[255:128]);
            if (hl > 14)
                mac_value = aes128(mac_value ^ abuf[127:0]);
        end
        in_session = 1'b1;
    endtask

    task automatic predict_ccm_beat(input logic [1:0] op, input logic [135:0] beat);
        logic [127:0] blk, ks, outb, plain, tagv;
        ccm_result_t  res;
        int           n, m;
        blk = {beat[63:0], beat[127:64]};
        n = (beat[132:128] > 16) ? 16 : int'(beat[132:128]);
        if (op == OP_HEADER) begin
            if (!in_session)
                for (int i = 0; i < n && hdr_seen < header_bytes(); i++) begin
                    hdr_bytes[255 - 8 * hdr_seen -: 8] = blk[127 - 8 * i -: 8];
                    hdr_seen++;
                end
            return;
        end
        if (op == OP_NONE) return;
        if (!in_session) open_session();
        if (op == OP_PAYLOAD) begin
            ks    = aes128({8'h01, nonce_hi, nonce_lo, ctr_index});
            outb  = (blk ^ ks) & keep_bytes(n);
            plain = opening ? outb : (blk & keep_bytes(n));
            if (n != 0) begin
                mac_value = aes128(mac_value ^ plain);
                ctr_index = ctr_index + 16'd1;
            end
            res = '{KIND_DATA, outb[127:64], outb[63:0], 5'(n), 1'b0};
        end else begin
            m    = tag_bytes();
            ks   = aes128({8'h01, nonce_hi, nonce_lo, 16'd0});
            tagv = (mac_value ^ ks) & keep_bytes(m);
            if (opening)
                res = '{KIND_VERDICT, '0, '0, '0, tagv == (blk & keep_bytes(m))};
            else
                res = '{KIND_TAG, tagv[127:64], tagv[63:0], 5'(m), 1'b0};
            clear_session();
        end
        expected_results.push_back(res);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fails < 40)
            $display("ccm_checker: %s mismatch at %0t: got %h expected %h",
                     what, $realtime, got, want);
        fails++;
    endtask

    task automatic compare_result();
        ccm_result_t want;
        if (expected_results.size() == 0) begin
            report("unexpected result beat", {62'd0, m_tuser}, '0);
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser != want.kind)           report("kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[63:0] != want.hi)       report("result_high", m_tdata[63:0], want.hi);
        if (m_tdata[127:64] != want.lo)     report("result_low", m_tdata[127:64], want.lo);
        if (m_tdata[132:128] != want.nbytes)
            report("result_bytes", 64'(m_tdata[132:128]), 64'(want.nbytes));
        if (m_tdata[133] != want.match)
            report("tag_match", 64'(m_tdata[133]), 64'(want.match));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_hi   = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0;
            tag_len  = 5'd4; hdr_len = '0; msg_len = '0; opening = 1'b0;
            clear_session();
            expected_results.delete();
            fails = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_KEY_HIGH:   key_hi   = cfg_data;
                    CFG_KEY_LOW:    key_lo   = cfg_data;
                    CFG_NONCE_HIGH: nonce_hi = cfg_data;
                    CFG_NONCE_LOW:  nonce_lo = cfg_data[39:0];
                    CFG_TAG_LEN:    tag_len  = cfg_data[4:0];
                    CFG_HDR_LEN:    hdr_len  = cfg_data[4:0];
                    CFG_MSG_LEN:    msg_len  = cfg_data[15:0];
                    CFG_OPEN_MODE:  opening  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_ccm_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) compare_result();
        end
        pending = expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the AES-128 CCM seal/open block
// Runs sealing sessions with random keys, nonces, lengths and data, then
// replays most of them in open mode with the produced ciphertext and tag,
// intact or corrupted. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import accm_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        op_t          op;
        logic [127:0] blk;
        logic [4:0]   nbytes;
    } ccm_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    int           pending, fails;

    int           send_idle = 0, recv_stall = 0, beats_sent = 0, cycles = 0;
    ccm_beat_t    sealed_out[$];

    aes_ccm_seal_open_top i_dut (.*);

    ccm_checker i_checker (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= recv_stall);

    // Keep produced results so that an open session can replay them.
    always @(posedge aclk)
        if (m_tvalid && m_tready)
            sealed_out.push_back('{op_t'(m_tuser), {m_tdata[63:0], m_tdata[127:64]},
                                   m_tdata[132:128]});

    task automatic send_beat(input op_t op, input logic [127:0] blk, input logic [4:0] nb);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'd0, nb, blk[63:0], blk[127:64]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [4:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 5'd16;
        if (r < 70) return 5'($urandom_range(31));
        return 5'($urandom_range(1, 15));
    endfunction

    // One sealing session, then optionally the matching open session.
    task automatic run_session(input int n_hdr, input int n_pay, input bit replay,
                               input bit spoil);
        ccm_beat_t sent[$];
        ccm_beat_t b, r;
        for (int i = 0; i < n_hdr; i++)
            sent.push_back('{OP_HEADER, rand_block(), 5'($urandom_range(31))});
        for (int i = 0; i < n_pay; i++) begin
            if ($urandom_range(9) == 0)
                sent.push_back('{$urandom_range(1) ? OP_NONE : OP_HEADER, rand_block(),
                                 rand_count()});
            sent.push_back('{OP_PAYLOAD, rand_block(), rand_count()});
        end
        sent.push_back('{OP_FINISH, rand_block(), 5'($urandom_range(31))});
        sealed_out.delete();
        write_reg(CFG_OPEN_MODE, {$urandom, $urandom} & ~64'd1);
        foreach (sent[i]) send_beat(sent[i].op, sent[i].blk, sent[i].nbytes);
        drain();
        if (!replay) return;
        write_reg(CFG_OPEN_MODE, 64'd1);
        foreach (sent[i]) begin
            b = sent[i];
            if (b.op == OP_PAYLOAD || b.op == OP_FINISH) begin
                r = sealed_out.pop_front();
                b.blk = r.blk;
                if (b.op == OP_FINISH) begin
                    b.blk = b.blk | (rand_block() & ~({128{1'b1}} << (128 - 8 * r.nbytes)));
                    if (spoil) b.blk[127 - $urandom_range(8 * r.nbytes - 1)] ^= 1'b1;
                end
            end
            send_beat(b.op, b.blk, b.nbytes);
        end
        drain();
    endtask

    task automatic set_session_regs(input logic [4:0] tag_len, input logic [4:0] hdr_len,
                                    input logic [15:0] msg_len);
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_NONCE_HIGH, {$urandom, $urandom});
        write_reg(CFG_NONCE_LOW, {$urandom, $urandom});
        write_reg(CFG_TAG_LEN, {$urandom, 27'd0, tag_len});
        write_reg(CFG_HDR_LEN, {59'd0, hdr_len});
        write_reg(CFG_MSG_LEN, {48'd0, msg_len});
    endtask

    initial begin
        int session;
        logic [4:0] hl;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: reset registers, finish with no payload, a zero-byte payload, oversized lengths.
        send_beat(OP_FINISH, '0, 5'd0);
        send_beat(OP_PAYLOAD, '1, 5'd0);
        send_beat(OP_PAYLOAD, '1, 5'd16);
        send_beat(OP_FINISH, '1, 5'd31);
        drain();
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_NONCE_HIGH, '1);
        write_reg(CFG_NONCE_LOW, '1);
        write_reg(CFG_TAG_LEN, 64'd31);
        write_reg(CFG_HDR_LEN, 64'd31);
        write_reg(CFG_MSG_LEN, '1);
        write_reg(CFG_OPEN_MODE, 64'd0);
        send_beat(OP_HEADER, '1, 5'd17);
        send_beat(OP_HEADER, rand_block(), 5'd31);
        send_beat(OP_NONE, '1, 5'd16);
        send_beat(OP_PAYLOAD, rand_block(), 5'd31);
        send_beat(OP_PAYLOAD, rand_block(), 5'd1);
        send_beat(OP_HEADER, rand_block(), 5'd16);
        send_beat(OP_FINISH, '0, 5'd0);
        drain();
        set_session_regs(5'd0, 5'd14, 16'd0);
        run_session(1, 1, 1'b1, 1'b0);
        set_session_regs(5'd3, 5'd15, 16'd1);
        run_session(2, 0, 1'b1, 1'b1);
        set_session_regs(5'd17, 5'd30, 16'hffff);
        run_session(1, 2, 1'b1, 1'b0);

        session = 0;
        while (beats_sent < 1100) begin
            case ((session / 4) % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            hl = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(30));
            set_session_regs(5'($urandom_range(31)), hl, 16'($urandom));
            run_session($urandom_range(3), $urandom_range(8), $urandom_range(3) != 0,
                        $urandom_range(1));
            session++;
        end

        drain();
        if (fails == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== aes_ccm_seal_open_top.f =====
src/accm_pkg.sv
src/accm_aes_core.sv
src/accm_front.sv
src/accm_back.sv
src/aes_ccm_seal_open_top.sv
test/ccm_checker.sv
test/tb.sv
